// File: hdl/y86dec_pkg.sv
// Shared types, opcode codes and the opcode classification function for the
// Y86-64 byte decoder. No dependencies; imported by every module of the block.
`default_nettype none

package y86dec_pkg;

  // Instruction codes (high nibble of the opcode byte)
  localparam logic [3:0] ICODE_HALT   = 4'h0;
  localparam logic [3:0] ICODE_NOP    = 4'h1;
  localparam logic [3:0] ICODE_RRMOVQ = 4'h2;
  localparam logic [3:0] ICODE_IRMOVQ = 4'h3;
  localparam logic [3:0] ICODE_RMMOVQ = 4'h4;
  localparam logic [3:0] ICODE_MRMOVQ = 4'h5;
  localparam logic [3:0] ICODE_OPQ    = 4'h6;
  localparam logic [3:0] ICODE_JXX    = 4'h7;
  localparam logic [3:0] ICODE_CALL   = 4'h8;
  localparam logic [3:0] ICODE_RET    = 4'h9;
  localparam logic [3:0] ICODE_PUSHQ  = 4'hA;
  localparam logic [3:0] ICODE_POPQ   = 4'hB;
  localparam logic [3:0] ICODE_IOPQ   = 4'hC;

  // Highest legal function code per family
  localparam logic [3:0] FN_MAX_OPQ  = 4'd3;
  localparam logic [3:0] FN_MAX_JXX  = 4'd6;
  localparam logic [3:0] FN_MAX_IOPQ = 4'd3;
  localparam logic [3:0] FN_NONE     = 4'd0;

  // Dense mnemonic codes
  localparam logic [4:0] MN_HALT   = 5'd0;
  localparam logic [4:0] MN_NOP    = 5'd1;
  localparam logic [4:0] MN_RRMOVQ = 5'd2;
  localparam logic [4:0] MN_IRMOVQ = 5'd3;
  localparam logic [4:0] MN_RMMOVQ = 5'd4;
  localparam logic [4:0] MN_MRMOVQ = 5'd5;
  localparam logic [4:0] MN_OPQ    = 5'd6;
  localparam logic [4:0] MN_JXX    = 5'd10;
  localparam logic [4:0] MN_CALL   = 5'd17;
  localparam logic [4:0] MN_RET    = 5'd18;
  localparam logic [4:0] MN_PUSHQ  = 5'd19;
  localparam logic [4:0] MN_POPQ   = 5'd20;
  localparam logic [4:0] MN_IOPQ   = 5'd21;
  localparam logic [4:0] MN_LAST   = 5'd24;

  // Instruction lengths
  localparam logic [3:0] LEN_1  = 4'd1;
  localparam logic [3:0] LEN_2  = 4'd2;
  localparam logic [3:0] LEN_9  = 4'd9;
  localparam logic [3:0] LEN_10 = 4'd10;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_INV   = 2'd1;
  localparam logic [1:0] ST_REG15 = 2'd2;
  localparam logic [1:0] ST_TRUNC = 2'd3;

  localparam logic [3:0] REG_NONE  = 4'hF;
  localparam logic [7:0] REGB_NONE = 8'hFF;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       end_of_stream;
  } in_t;

  typedef struct packed {
    logic [4:0]  mnemonic;
    logic [3:0]  reg_a;
    logic [3:0]  reg_b;
    logic [63:0] constant_value;
    logic [3:0]  instr_length;
    logic [1:0]  status;
  } out_t;

  // Opcode classification
  typedef struct packed {
    logic       valid;
    logic [4:0] mnem;
    logic [3:0] len;
    logic       use_a;
    logic       use_b;
  } dec_t;

  // Tagged byte handed from the front to the back
  typedef struct packed {
    logic [7:0] data;       // the code byte
    logic       first;      // opcode byte: clear register/constant collection
    logic       is_reg;     // register byte
    logic       is_const;   // constant byte
    logic [2:0] kidx;       // constant byte position, little endian
    logic       emit;       // this byte closes a record
    logic       chk_reg;    // apply the register 15 check on close
    logic [1:0] status;     // status unless the register check fires
    logic [4:0] mnem;
    logic [3:0] len;
    logic       use_a;
    logic       use_b;
  } rec_t;

  function automatic dec_t decode_op(input logic [7:0] op);
    dec_t       d;
    logic [3:0] ic;
    logic [3:0] fn;
    ic = op[7:4];
    fn = op[3:0];
    d  = '{valid: 1'b0, mnem: MN_HALT, len: LEN_1, use_a: 1'b0, use_b: 1'b0};
    case (ic)
      ICODE_HALT: begin
        d.mnem = MN_HALT; d.len = LEN_1; d.valid = (fn == FN_NONE);
      end
      ICODE_NOP: begin
        d.mnem = MN_NOP; d.len = LEN_1; d.valid = (fn == FN_NONE);
      end
      ICODE_RRMOVQ: begin
        d.mnem = MN_RRMOVQ; d.len = LEN_2; d.use_a = 1'b1; d.use_b = 1'b1;
        d.valid = (fn == FN_NONE);
      end
      ICODE_IRMOVQ: begin
        d.mnem = MN_IRMOVQ; d.len = LEN_10; d.use_b = 1'b1; d.valid = (fn == FN_NONE);
      end
      ICODE_RMMOVQ: begin
        d.mnem = MN_RMMOVQ; d.len = LEN_10; d.use_a = 1'b1; d.use_b = 1'b1;
        d.valid = (fn == FN_NONE);
      end
      ICODE_MRMOVQ: begin
        d.mnem = MN_MRMOVQ; d.len = LEN_10; d.use_a = 1'b1; d.use_b = 1'b1;
        d.valid = (fn == FN_NONE);
      end
      ICODE_OPQ: begin
        d.mnem = MN_OPQ + {1'b0, fn}; d.len = LEN_2; d.use_a = 1'b1; d.use_b = 1'b1;
        d.valid = (fn <= FN_MAX_OPQ);
      end
      ICODE_JXX: begin
        d.mnem = MN_JXX + {1'b0, fn}; d.len = LEN_9; d.valid = (fn <= FN_MAX_JXX);
      end
      ICODE_CALL: begin
        d.mnem = MN_CALL; d.len = LEN_9; d.valid = (fn == FN_NONE);
      end
      ICODE_RET: begin
        d.mnem = MN_RET; d.len = LEN_1; d.valid = (fn == FN_NONE);
      end
      ICODE_PUSHQ: begin
        d.mnem = MN_PUSHQ; d.len = LEN_2; d.use_a = 1'b1; d.valid = (fn == FN_NONE);
      end
      ICODE_POPQ: begin
        d.mnem = MN_POPQ; d.len = LEN_2; d.use_a = 1'b1; d.valid = (fn == FN_NONE);
      end
      ICODE_IOPQ: begin
        d.mnem = MN_IOPQ + {1'b0, fn}; d.len = LEN_10; d.use_b = 1'b1;
        d.valid = (fn <= FN_MAX_IOPQ);
      end
      default: d.valid = 1'b0;
    endcase
    // invalid opcodes collapse to a one-byte record
    if (!d.valid) begin
      d.mnem  = MN_HALT;
      d.len   = LEN_1;
      d.use_a = 1'b0;
      d.use_b = 1'b0;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// File: hdl/y86dec_front.sv
// Front end: accepts code bytes, tracks instruction boundaries and tags each
// byte with its role. Depends on y86dec_pkg.
`default_nettype none

module y86dec_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire y86dec_pkg::in_t   in_data,
  input  wire logic              q_full,
  output      logic              q_push,
  output      y86dec_pkg::rec_t  q_rec
);
  import y86dec_pkg::*;

  logic       busy_r,    busy_nxt;
  logic [3:0] cnt_r,     cnt_nxt;
  logic [3:0] exp_r,     exp_nxt;
  logic [4:0] mnem_r,    mnem_nxt;
  logic       use_a_r,   use_a_nxt;
  logic       use_b_r,   use_b_nxt;
  logic       has_reg_r, has_reg_nxt;

  dec_t       d;
  logic [3:0] cnt_inc;
  logic [3:0] kpos;
  logic       done;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  assign d       = decode_op(in_data.code_byte);
  assign cnt_inc = cnt_r + 4'd1;
  assign kpos    = cnt_r - (has_reg_r ? 4'd2 : 4'd1);
  assign done    = (cnt_inc >= exp_r);

  // Tag the byte and work out the next boundary state
  always_comb begin
    busy_nxt    = busy_r;
    cnt_nxt     = cnt_r;
    exp_nxt     = exp_r;
    mnem_nxt    = mnem_r;
    use_a_nxt   = use_a_r;
    use_b_nxt   = use_b_r;
    has_reg_nxt = has_reg_r;
    q_rec       = '0;
    q_rec.data  = in_data.code_byte;

    if (!busy_r) begin
      // opcode byte
      q_rec.first = 1'b1;
      q_rec.mnem  = d.mnem;
      q_rec.len   = LEN_1;
      q_rec.use_a = d.use_a;
      q_rec.use_b = d.use_b;
      if (!d.valid) begin
        q_rec.emit   = 1'b1;
        q_rec.status = ST_INV;
      end else if (d.len == LEN_1) begin
        q_rec.emit   = 1'b1;
        q_rec.status = ST_OK;
      end else if (in_data.end_of_stream) begin
        q_rec.emit   = 1'b1;
        q_rec.status = ST_TRUNC;
      end else if (q_push) begin
        busy_nxt    = 1'b1;
        cnt_nxt     = 4'd1;
        exp_nxt     = d.len;
        mnem_nxt    = d.mnem;
        use_a_nxt   = d.use_a;
        use_b_nxt   = d.use_b;
        has_reg_nxt = (d.len == LEN_2) || (d.len == LEN_10);
      end
    end else begin
      // register or constant byte
      q_rec.mnem     = mnem_r;
      q_rec.use_a    = use_a_r;
      q_rec.use_b    = use_b_r;
      q_rec.is_reg   = has_reg_r && (cnt_r == 4'd1);
      q_rec.is_const = !(has_reg_r && (cnt_r == 4'd1));
      q_rec.kidx     = kpos[2:0];
      if (done) begin
        q_rec.emit    = 1'b1;
        q_rec.chk_reg = 1'b1;
        q_rec.status  = ST_OK;
        q_rec.len     = exp_r;
      end else if (in_data.end_of_stream) begin
        q_rec.emit   = 1'b1;
        q_rec.status = ST_TRUNC;
        q_rec.len    = cnt_inc;
      end else begin
        q_rec.len = cnt_inc;
      end
      if (q_push) begin
        if (done || in_data.end_of_stream) begin
          busy_nxt = 1'b0;
          cnt_nxt  = 4'd0;
          exp_nxt  = 4'd0;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 4'd0;
      exp_r  <= 4'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      exp_r  <= exp_nxt;
    end
  end

  // Per-instruction attributes, loaded on the opcode byte
  always_ff @(posedge clk) begin
    mnem_r    <= mnem_nxt;
    use_a_r   <= use_a_nxt;
    use_b_r   <= use_b_nxt;
    has_reg_r <= has_reg_nxt;
  end

endmodule

`default_nettype wire

// File: hdl/y86dec_queue.sv
// Two-entry queue of tagged bytes between the front and back ends.
// Depends on y86dec_pkg.
`default_nettype none

module y86dec_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire y86dec_pkg::rec_t  push_rec,
  output      logic              full,
  input  wire logic              pop,
  output      logic              not_empty,
  output      y86dec_pkg::rec_t  head_rec
);
  import y86dec_pkg::*;

  rec_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r,   fill_nxt;

  assign full      = (fill_r == 2'd2);
  assign not_empty = (fill_r != 2'd0);
  assign head_rec  = slot_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

`default_nettype wire

// File: hdl/y86dec_back.sv
// Back end: collects the register byte and constant, builds the decoded
// record and holds it in the output register. Depends on y86dec_pkg.
`default_nettype none

module y86dec_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_not_empty,
  input  wire y86dec_pkg::rec_t  q_rec,
  output      logic              q_pop,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      y86dec_pkg::out_t  out_data
);
  import y86dec_pkg::*;

  logic [7:0]  regb_r, regb_nxt;
  logic [63:0] acc_r,  acc_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_data_r,  out_data_nxt;

  logic [7:0]  regb_cur;
  logic [63:0] acc_base;
  logic [63:0] acc_cur;
  logic        reg_bad;
  logic        load_out;

  // Byte is taken unless it closes a record and the output is still held
  assign q_pop    = q_not_empty && (!q_rec.emit || !out_valid_r || out_ready);
  assign load_out = q_pop && q_rec.emit;

  // Merge the current byte into the collected fields
  always_comb begin
    regb_cur = q_rec.first ? REGB_NONE : regb_r;
    if (q_rec.is_reg) begin
      regb_cur = q_rec.data;
    end
    acc_base = q_rec.first ? 64'd0 : acc_r;
    acc_cur  = acc_base;
    if (q_rec.is_const) begin
      acc_cur = acc_base | ({56'd0, q_rec.data} << {q_rec.kidx, 3'b000});
    end
    reg_bad = (q_rec.use_a && (regb_cur[7:4] == REG_NONE)) ||
              (q_rec.use_b && (regb_cur[3:0] == REG_NONE));
  end

  // Collection state and output register next values
  always_comb begin
    regb_nxt      = regb_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (q_pop) begin
      if (q_rec.emit) begin
        regb_nxt = REGB_NONE;
        acc_nxt  = 64'd0;
      end else begin
        regb_nxt = regb_cur;
        acc_nxt  = acc_cur;
      end
    end
    if (load_out) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.mnemonic       = q_rec.mnem;
      out_data_nxt.reg_a          = regb_cur[7:4];
      out_data_nxt.reg_b          = regb_cur[3:0];
      out_data_nxt.constant_value = acc_cur;
      out_data_nxt.instr_length   = q_rec.len;
      out_data_nxt.status         = (q_rec.chk_reg && reg_bad) ? ST_REG15 : q_rec.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      regb_r      <= REGB_NONE;
      acc_r       <= 64'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      regb_r      <= regb_nxt;
      acc_r       <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: hdl/y86_instruction_byte_decoder.sv
// Top level of the Y86-64 byte decoder: front end, two-entry queue, back end.
// Depends on y86dec_pkg, y86dec_front, y86dec_queue and y86dec_back.
//
//   channel | direction | payload        | meaning
//   in_     | input     | in_t   (9 b)   | one code byte, end-of-stream flag
//   out_    | output    | out_t  (83 b)  | one decoded instruction record
//
// One code byte per cycle is sustained while out_ is not stalled; a record
// enters the output register in the cycle after its last byte is taken from
// the queue (the byte passes a queue slot, then the output register).
// Reset is synchronous, active low, and clears the boundary tracker, the
// queue and the output valid flag. A stall at out_ blocks only bytes that
// close a record; the queue absorbs two bytes before in_ready drops.
`default_nettype none

module y86_instruction_byte_decoder (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire y86dec_pkg::in_t   in_data,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      y86dec_pkg::out_t  out_data
);
  import y86dec_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_not_empty;
  rec_t push_rec;
  rec_t head_rec;

  y86dec_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_rec    (push_rec)
  );

  y86dec_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_rec  (push_rec),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_rec  (head_rec)
  );

  y86dec_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_rec       (head_rec),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

// File: hdl/y86dec_checker.sv
// Port-level checks for the Y86-64 byte decoder, bound to the top level.
// Depends on y86dec_pkg and y86_instruction_byte_decoder.
`default_nettype none

module y86dec_checker (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire y86dec_pkg::out_t out_data
);
  import y86dec_pkg::*;

  // A held record stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A held record keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  // Lengths are one to ten bytes
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.instr_length != 4'd0) && (out_data.instr_length <= LEN_10))
    else $error("instruction length out of range");

  // Invalid opcodes are single-byte halt records with reg_a unset and a zero constant
  a_inv_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_INV) |->
      (out_data.instr_length == LEN_1) && (out_data.mnemonic == MN_HALT) &&
      (out_data.reg_a == REG_NONE) && (out_data.constant_value == 64'd0))
    else $error("malformed invalid-opcode record");

  // Mnemonic stays in the dense code range
  a_mnem_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.mnemonic <= MN_LAST)
    else $error("mnemonic out of range");

endmodule

bind y86_instruction_byte_decoder y86dec_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
